>>> hdl/piecewise_linear_interpolator_defines.svh
// Assertion macros used by the interpolator controller RTL.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTH

// Consequent holds in the same cycle as the antecedent
`define PWL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Consequent holds in the cycle after the antecedent
`define PWL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define PWL_ASSERT_SAME(label, clk, rst, ante, cons)
`define PWL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hdl/pwl_pkg.sv
package pwl_pkg;

   // Field widths
   localparam int unsigned KEY_W  = 16;
   localparam int unsigned VAL_W  = 32;
   localparam int unsigned IDX_W  = 5;
   localparam int unsigned SIZE_W = 6;

   // Table depth default and table size after reset
   localparam int unsigned        DEF_MAX_POINTS   = 32;
   localparam logic [SIZE_W-1:0]  TABLE_SIZE_RESET = 6'd32;

   // Item opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Restoring divider: 32-bit dividend, one quotient bit per step
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic latch_x;    // capture query key
      logic wr_en;      // load transfer: write one table point
      logic rd_en;      // read table entry at rd_addr
      logic save_prev;  // move read entry into the previous-point register
      logic take_rd;    // result is the value of the read entry
      logic take_prev;  // result is the previous-point value
      logic setup;      // prepare segment width, offset and value delta
      logic div_step;   // one restoring divide step
      logic mul;        // fraction times value delta
      logic add;        // y0 plus scaled delta
      logic load_out;   // move result into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic x_le_key;   // query key <= read key
      logic x_ge_key;   // query key >= read key
      logic seg_hit;    // previous key <= query key <= read key
      logic w_zero;     // segment has zero width
   } sts_type;

endpackage

>>> hdl/pwl_dp.sv
module pwl_dp #(
   parameter int unsigned MAX_POINTS = pwl_pkg::DEF_MAX_POINTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [pwl_pkg::SIZE_W-1:0]        csr_wr_data,
   input  logic [pwl_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [pwl_pkg::KEY_W-1:0]         req_key_value,
   input  logic signed [pwl_pkg::VAL_W-1:0]  req_entry_value,
   input  logic [$clog2(MAX_POINTS)-1:0]     rd_addr,
   input  pwl_pkg::cmd_type                  cmd,
   output pwl_pkg::sts_type                  sts,
   output logic [$clog2(MAX_POINTS)-1:0]     last_idx,
   output logic signed [pwl_pkg::VAL_W-1:0]  rsp_result_value
);
   import pwl_pkg::*;

   localparam int unsigned AW    = $clog2(MAX_POINTS);
   localparam int unsigned ENT_W = KEY_W + VAL_W;
   localparam int unsigned DIF_W = VAL_W + 1;
   localparam int unsigned T_W   = KEY_W + 2;
   localparam int unsigned PRD_W = DIF_W + T_W;

   logic [SIZE_W-1:0]       table_size_ff;
   logic [ENT_W-1:0]        mem_ff [MAX_POINTS];
   logic [ENT_W-1:0]        rd_data_ff;
   logic [KEY_W-1:0]        x_ff;
   logic [KEY_W-1:0]        prev_key_ff;
   logic signed [VAL_W-1:0] prev_val_ff;
   logic [KEY_W-1:0]        w_ff;
   logic [KEY_W-1:0]        rem_ff;
   logic [VAL_W-1:0]        quo_ff;
   logic signed [DIF_W-1:0] diff_ff;
   logic signed [PRD_W-1:0] prod_ff;
   logic signed [VAL_W-1:0] res_ff;
   logic signed [VAL_W-1:0] out_ff;

   logic [KEY_W-1:0]        rd_key;
   logic signed [VAL_W-1:0] rd_val;
   logic                    wr_ok;
   logic [KEY_W:0]          shl;
   logic [KEY_W:0]          trial;
   logic                    qbit;
   logic [KEY_W-1:0]        rem_in;
   logic [VAL_W-1:0]        quo_in;
   logic signed [DIF_W-1:0] diff_in;
   logic signed [T_W-1:0]   t_s;
   logic signed [PRD_W-1:0] prod_in;
   logic signed [VAL_W-1:0] res_in;

   assign rd_key = rd_data_ff[ENT_W-1:VAL_W];
   assign rd_val = $signed(rd_data_ff[VAL_W-1:0]);

   // Table size register
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else if (csr_wr_en) begin
         table_size_ff <= csr_wr_data;
      end
   end

   // Clamp table size to 1..MAX_POINTS and give the last index in use
   always_comb begin
      if (table_size_ff == '0) begin
         last_idx = '0;
      end else if (32'(table_size_ff) > 32'(MAX_POINTS)) begin
         last_idx = AW'(MAX_POINTS - 1);
      end else begin
         last_idx = AW'(table_size_ff - SIZE_W'(1));
      end
   end

   // Table memory: one write port for loads, one registered read port
   assign wr_ok = 32'(req_entry_index) < 32'(MAX_POINTS);

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_ok) begin
         mem_ff[AW'(req_entry_index)] <= {req_key_value, req_entry_value};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Comparisons for the segment search
   always_comb begin
      sts.x_le_key = x_ff <= rd_key;
      sts.x_ge_key = x_ff >= rd_key;
      sts.seg_hit  = (prev_key_ff <= x_ff) && (x_ff <= rd_key);
      sts.w_zero   = rd_key == prev_key_ff;
   end

   // Restoring divide step
   always_comb begin
      shl   = {rem_ff, quo_ff[VAL_W-1]};
      trial = shl - {1'b0, w_ff};
      qbit  = shl >= {1'b0, w_ff};
      if (cmd.setup) begin
         rem_in = '0;
         quo_in = {x_ff - prev_key_ff, {(VAL_W-KEY_W){1'b0}}};
      end else begin
         rem_in = qbit ? trial[KEY_W-1:0] : shl[KEY_W-1:0];
         quo_in = {quo_ff[VAL_W-2:0], qbit};
      end
   end

   // Value delta, fraction product and final sum
   always_comb begin
      diff_in = $signed({rd_val[VAL_W-1], rd_val})
              - $signed({prev_val_ff[VAL_W-1], prev_val_ff});
      t_s     = $signed({1'b0, quo_ff[KEY_W:0]});
      prod_in = t_s * diff_ff;
      res_in  = prev_val_ff + $signed(prod_ff[VAL_W+KEY_W-1:KEY_W]);
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (cmd.latch_x) begin
         x_ff <= req_key_value;
      end
      if (cmd.save_prev) begin
         prev_key_ff <= rd_key;
         prev_val_ff <= rd_val;
      end
      if (cmd.setup) begin
         w_ff    <= rd_key - prev_key_ff;
         diff_ff <= diff_in;
      end
      if (cmd.setup || cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.take_rd) begin
         res_ff <= rd_val;
      end else if (cmd.take_prev) begin
         res_ff <= prev_val_ff;
      end else if (cmd.add) begin
         res_ff <= res_in;
      end
      if (cmd.load_out) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_result_value = out_ff;

endmodule

>>> hdl/pwl_ctrl.sv
`include "piecewise_linear_interpolator_defines.svh"

module pwl_ctrl #(
   parameter int unsigned MAX_POINTS = pwl_pkg::DEF_MAX_POINTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [$clog2(MAX_POINTS)-1:0]  last_idx,
   output logic [$clog2(MAX_POINTS)-1:0]  rd_addr,
   output pwl_pkg::cmd_type               cmd,
   input  pwl_pkg::sts_type               sts
);
   import pwl_pkg::*;

   localparam int unsigned AW = $clog2(MAX_POINTS);
   localparam logic [AW-1:0]        IDX_ONE  = AW'(1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FIRST  = 4'd1;
   localparam logic [3:0] S_LAST   = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_SETUP  = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_MUL    = 4'd6;
   localparam logic [3:0] S_ADD    = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // Sequence one item: a load, or a query's clamp checks, segment scan, divide, multiply, add
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rd_addr      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_QUERY) begin
                  cmd.latch_x = 1'b1;
                  cmd.rd_en   = 1'b1;
                  state_in    = S_FIRST;
               end else begin
                  cmd.wr_en = 1'b1;
               end
            end
         end
         S_FIRST: begin
            if (sts.x_le_key) begin
               cmd.take_rd = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.save_prev = 1'b1;
               cmd.rd_en     = 1'b1;
               rd_addr       = last_idx;
               state_in      = S_LAST;
            end
         end
         S_LAST: begin
            if (sts.x_ge_key) begin
               cmd.take_rd = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = IDX_ONE;
               idx_in    = IDX_ONE;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.seg_hit) begin
               state_in = S_SETUP;
            end else if (idx_ff == last_idx) begin
               cmd.take_rd = 1'b1;
               state_in    = S_FINISH;
            end else begin
               cmd.save_prev = 1'b1;
               cmd.rd_en     = 1'b1;
               rd_addr       = idx_ff + IDX_ONE;
               idx_in        = idx_ff + IDX_ONE;
            end
         end
         S_SETUP: begin
            if (sts.w_zero) begin
               cmd.take_prev = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.setup = 1'b1;
               cnt_in    = '0;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PWL_ASSERT_NEXT(a_query_starts_scan, clock, reset, req_valid && req_ready && req_op == OP_QUERY, state_ff == S_FIRST)
   `PWL_ASSERT_NEXT(a_finish_holds_on_stall, clock, reset, state_ff == S_FINISH && rsp_valid_ff && !rsp_ready, state_ff == S_FINISH)
   `PWL_ASSERT_SAME(a_scan_in_range, clock, reset, state_ff == S_SCAN, idx_ff <= last_idx && idx_ff != '0)
   `PWL_ASSERT_SAME(a_full_divide, clock, reset, state_ff == S_MUL, $past(state_ff) == S_DIV && $past(cnt_ff) == DIV_LAST)

endmodule

>>> hdl/piecewise_linear_interpolator.sv
// Piecewise-linear table interpolator, 1-D, fixed point.
// Request channel (req_valid/req_ready): req_op selects a load, which writes
// key req_key_value and value req_entry_value at req_entry_index, or a query
// of key req_key_value. Loads give no response; each query gives one
// rsp_result_value on the response channel (rsp_valid/rsp_ready).
// csr_wr_en/csr_wr_data set the number of breakpoints in use; write it only
// while the block is idle.
// A load writes its table point as it transfers and leaves the block ready.
// A query at or below the first breakpoint answers with that value, one at
// or above the last breakpoint with its value. A query inside segment j
// (1..size-1) runs a scan reading one table entry per cycle through the
// single memory read port, then a 32-step restoring divider, one multiply
// and one add. One query is in work at a time; the next request transfers
// once the result sits in the output register.
// Reset clears the controller, empties the output register and sets the
// table size to 32; table contents are undefined until loaded.
// When the receiver stalls, the response holds in the output register; a
// following query runs to completion and then waits until the register
// frees, with req_ready low.
module piecewise_linear_interpolator #(
   parameter int unsigned MAX_POINTS = pwl_pkg::DEF_MAX_POINTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [pwl_pkg::IDX_W-1:0]         req_entry_index,
   input  logic [pwl_pkg::KEY_W-1:0]         req_key_value,
   input  logic signed [pwl_pkg::VAL_W-1:0]  req_entry_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pwl_pkg::VAL_W-1:0]  rsp_result_value,
   input  logic                              csr_wr_en,
   input  logic [pwl_pkg::SIZE_W-1:0]        csr_wr_data
);
   import pwl_pkg::*;

   localparam int unsigned AW = $clog2(MAX_POINTS);

   cmd_type       cmd;
   sts_type       sts;
   logic [AW-1:0] last_idx;
   logic [AW-1:0] rd_addr;

   pwl_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .last_idx  (last_idx),
      .rd_addr   (rd_addr),
      .cmd       (cmd),
      .sts       (sts)
   );

   pwl_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_entry_index  (req_entry_index),
      .req_key_value    (req_key_value),
      .req_entry_value  (req_entry_value),
      .rd_addr          (rd_addr),
      .cmd              (cmd),
      .sts              (sts),
      .last_idx         (last_idx),
      .rsp_result_value (rsp_result_value)
   );

endmodule
